// ----- hdl/sldf_pkg.sv -----
// shared types and constants of the sync/length/checksum deframer
`default_nettype none
package sldf_pkg;

   localparam logic [7:0] SYNC_FIRST = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;
   localparam logic [15:0] SUM_INIT = 16'hFFFF;
   localparam logic [15:0] TICKS_MAX = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam int HDR_BYTES = 4;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_PAYLOAD  = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BAD_SUM  = 3'd2,
      ST_TIMEOUT  = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_BAD_LEN  = 3'd5
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/sldf_req_if.sv -----
// input channel: received byte or millisecond tick
`default_nettype none
interface sldf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/sldf_rsp_if.sv -----
// result channel: payload bytes and frame status
`default_nettype none
interface sldf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] frame_addr;
   logic [7:0] frame_hz;
   logic [7:0] frame_cmd;
   logic [7:0] payload_byte;
   logic [5:0] payload_index;
   logic       last;

   modport source (output valid, output status, output frame_addr, output frame_hz,
                   output frame_cmd, output payload_byte, output payload_index,
                   output last, input ready);
   modport sink (input valid, input status, input frame_addr, input frame_hz,
                 input frame_cmd, input payload_byte, input payload_index,
                 input last, output ready);
endinterface
`default_nettype wire

// ----- hdl/sldf_csr_if.sv -----
// configuration write channel for the idle timeout register
`default_nettype none
interface sldf_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sldf_ram.sv -----
// generic single-write, single-read RAM with registered read data
`default_nettype none
module sldf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 58
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/sync_len_checksum_deframer_core.sv -----
// a status result is registered at the edge that accepts its input byte or tick
// throughput: one byte or tick per cycle while the result register is free and no payload burst runs
// a good frame of n payload bytes plays out of the payload RAM: a read state, then
//   up to one result per cycle while the result register is free; no input is taken during it
// reset: synchronous, active high; clears control, timeout back to 100 ms ticks;
//   the payload RAM is not cleared (only written entries are ever read)
`default_nettype none
module sync_len_checksum_deframer_core
   import sldf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   sldf_req_if.sink  req_if,
   sldf_rsp_if.source rsp_if,
   sldf_csr_if.sink  csr_if
);

   localparam int STORE_DEPTH = MAX_FRAME_BYTES - 6;
   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [7:0] MAX_W = 8'(MAX_FRAME_BYTES);
   localparam logic [7:0] DEPTH_W = 8'(STORE_DEPTH);

   typedef enum logic [1:0] {
      S_RUN,
      S_READ,
      S_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic        saw_sync_ff, saw_sync_in;
   logic        in_frame_ff, in_frame_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  hdr_len_ff, hdr_len_in;
   logic [7:0]  hdr_addr_ff, hdr_addr_in;
   logic [7:0]  hdr_hz_ff, hdr_hz_in;
   logic [7:0]  hdr_cmd_ff, hdr_cmd_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  sum_low_ff, sum_low_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [7:0]  burst_n_ff, burst_n_in;
   logic [7:0]  burst_idx_ff, burst_idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_addr_ff, rsp_addr_in;
   logic [7:0]  rsp_hz_ff, rsp_hz_in;
   logic [7:0]  rsp_cmd_ff, rsp_cmd_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [5:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   logic          out_free;
   logic          req_ready;
   logic          req_take;
   logic [7:0]    cnt;
   logic [7:0]    len;
   logic [8:0]    cnt9;
   logic [8:0]    len9;
   logic [7:0]    store_idx;
   logic [15:0]   ticks_next;
   logic [15:0]   got_sum;
   logic          finished;
   logic          emit_en;
   status_type    emit_status;
   logic [7:0]    emit_byte;
   logic [5:0]    emit_index;
   logic          emit_last;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   sldf_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_payload_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_if.rx_byte),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_ready = (state_ff == S_RUN) && out_free;
   assign req_take = req_if.valid && req_ready;

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.frame_addr = rsp_addr_ff;
   assign rsp_if.frame_hz = rsp_hz_ff;
   assign rsp_if.frame_cmd = rsp_cmd_ff;
   assign rsp_if.payload_byte = rsp_byte_ff;
   assign rsp_if.payload_index = rsp_index_ff;
   assign rsp_if.last = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      saw_sync_in = saw_sync_ff;
      in_frame_in = in_frame_ff;
      byte_count_in = byte_count_ff;
      hdr_len_in = hdr_len_ff;
      hdr_addr_in = hdr_addr_ff;
      hdr_hz_in = hdr_hz_ff;
      hdr_cmd_in = hdr_cmd_ff;
      sum_in = sum_ff;
      sum_low_in = sum_low_ff;
      idle_in = idle_ff;
      timeout_in = timeout_ff;
      burst_n_in = burst_n_ff;
      burst_idx_in = burst_idx_ff;

      cnt = byte_count_ff + 8'd1;
      len = (cnt == 8'd1) ? req_if.rx_byte : hdr_len_ff;
      cnt9 = {1'b0, cnt};
      len9 = {1'b0, len};
      store_idx = cnt - 8'd5;
      ticks_next = (idle_ff == TICKS_MAX) ? idle_ff : idle_ff + 16'd1;
      got_sum = {req_if.rx_byte, sum_low_ff};
      finished = 1'b0;

      emit_en = 1'b0;
      emit_status = ST_PAYLOAD;
      emit_byte = 8'd0;
      emit_index = 6'd0;
      emit_last = 1'b1;

      ram_wr_en = 1'b0;
      ram_wr_addr = store_idx[AW-1:0];
      ram_rd_en = 1'b0;
      ram_rd_addr = burst_idx_ff[AW-1:0];

      if (csr_if.valid) begin
         timeout_in = csr_if.data;
      end

      case (state_ff)
         S_RUN: begin
            if (req_take) begin
               if (req_if.op == OP_TICK) begin
                  if (in_frame_ff) begin
                     idle_in = ticks_next;
                     if (ticks_next >= timeout_ff) begin
                        emit_en = 1'b1;
                        emit_status = ST_TIMEOUT;
                     end
                  end
               end else if (!in_frame_ff) begin
                  if (saw_sync_ff && req_if.rx_byte == SYNC_SECOND) begin
                     in_frame_in = 1'b1;
                     saw_sync_in = 1'b0;
                     byte_count_in = 8'd0;
                     hdr_len_in = 8'd0;
                     hdr_addr_in = 8'd0;
                     hdr_hz_in = 8'd0;
                     hdr_cmd_in = 8'd0;
                     sum_in = SUM_INIT;
                     sum_low_in = 8'd0;
                     idle_in = 16'd0;
                  end else begin
                     saw_sync_in = (req_if.rx_byte == SYNC_FIRST);
                  end
               end else begin
                  idle_in = 16'd0;
                  byte_count_in = cnt;
                  if (cnt <= 8'(HDR_BYTES)) begin
                     case (cnt[1:0])
                        2'd1:    hdr_len_in = req_if.rx_byte;
                        2'd2:    hdr_addr_in = req_if.rx_byte;
                        2'd3:    hdr_hz_in = req_if.rx_byte;
                        default: hdr_cmd_in = req_if.rx_byte;
                     endcase
                     sum_in = sum_ff - {8'd0, req_if.rx_byte};
                     if (cnt == 8'(HDR_BYTES) && len < 8'd2) begin
                        finished = 1'b1;
                        emit_en = 1'b1;
                        emit_status = ST_BAD_LEN;
                     end
                  end else if (cnt9 <= len9 + 9'd2) begin
                     ram_wr_en = (store_idx < DEPTH_W);
                     sum_in = sum_ff - {8'd0, req_if.rx_byte};
                  end else if (cnt9 == len9 + 9'd3) begin
                     sum_low_in = req_if.rx_byte;
                  end else if (cnt9 == len9 + 9'd4) begin
                     finished = 1'b1;
                     if (got_sum != sum_ff) begin
                        emit_en = 1'b1;
                        emit_status = ST_BAD_SUM;
                     end else if (len == 8'd2) begin
                        emit_en = 1'b1;
                        emit_status = ST_EMPTY;
                     end else begin
                        // good frame with payload: play it out of the RAM
                        in_frame_in = 1'b0;
                        saw_sync_in = 1'b0;
                        burst_n_in = len - 8'd2;
                        burst_idx_in = 8'd0;
                        state_in = S_READ;
                     end
                  end
                  if (!finished && cnt >= MAX_W) begin
                     emit_en = 1'b1;
                     emit_status = ST_OVERFLOW;
                  end
               end
               // every status result ends the frame
               if (emit_en) begin
                  in_frame_in = 1'b0;
                  saw_sync_in = 1'b0;
               end
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               emit_en = 1'b1;
               emit_status = ST_PAYLOAD;
               emit_byte = ram_rd_data;
               emit_index = burst_idx_ff[5:0];
               emit_last = (burst_idx_ff + 8'd1 == burst_n_ff);
               if (emit_last) begin
                  state_in = S_RUN;
               end else begin
                  // fetch the next byte while this one is loaded
                  burst_idx_in = burst_idx_ff + 8'd1;
                  ram_rd_en = 1'b1;
                  ram_rd_addr = burst_idx_in[AW-1:0];
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_hz_in = rsp_hz_ff;
      rsp_cmd_in = rsp_cmd_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in = rsp_last_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = emit_status;
         rsp_addr_in = hdr_addr_in;
         rsp_hz_in = hdr_hz_in;
         rsp_cmd_in = hdr_cmd_in;
         rsp_byte_in = emit_byte;
         rsp_index_in = emit_index;
         rsp_last_in = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         saw_sync_ff <= 1'b0;
         in_frame_ff <= 1'b0;
         byte_count_ff <= 8'd0;
         hdr_len_ff <= 8'd0;
         hdr_addr_ff <= 8'd0;
         hdr_hz_ff <= 8'd0;
         hdr_cmd_ff <= 8'd0;
         sum_ff <= SUM_INIT;
         sum_low_ff <= 8'd0;
         idle_ff <= 16'd0;
         timeout_ff <= TIMEOUT_RESET;
         burst_n_ff <= 8'd0;
         burst_idx_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         saw_sync_ff <= saw_sync_in;
         in_frame_ff <= in_frame_in;
         byte_count_ff <= byte_count_in;
         hdr_len_ff <= hdr_len_in;
         hdr_addr_ff <= hdr_addr_in;
         hdr_hz_ff <= hdr_hz_in;
         hdr_cmd_ff <= hdr_cmd_in;
         sum_ff <= sum_in;
         sum_low_ff <= sum_low_in;
         idle_ff <= idle_in;
         timeout_ff <= timeout_in;
         burst_n_ff <= burst_n_in;
         burst_idx_ff <= burst_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_hz_ff <= rsp_hz_in;
      rsp_cmd_ff <= rsp_cmd_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_no_input_during_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RUN) |-> !req_if.ready)
      else $error("input accepted while payload burst is running");

   a_status_has_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_PAYLOAD) |->
      (rsp_byte_ff == 8'd0 && rsp_index_ff == 6'd0 && rsp_last_ff))
      else $error("status result carries payload fields");

   a_frame_clears_sync: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> !saw_sync_ff)
      else $error("sync hunt armed inside a frame");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (byte_count_ff < MAX_W))
      else $error("frame byte count passed its limit");

   a_burst_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (burst_idx_ff < burst_n_ff && burst_n_ff <= DEPTH_W))
      else $error("payload burst index out of range");
`endif

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench for the sync/length/checksum deframer core
module tb
   import sldf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_MAX = 64;
   localparam int STORE_DEPTH = FRAME_MAX - 6;

   typedef struct {
      op_type     op;
      logic [7:0] rx_byte;
   } rx_item_type;

   typedef struct {
      status_type status;
      logic [7:0] addr;
      logic [7:0] hz;
      logic [7:0] cmd;
      logic [7:0] pbyte;
      logic [5:0] pidx;
      logic       last;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sldf_req_if req_ch ();
   sldf_rsp_if rsp_ch ();
   sldf_csr_if csr_ch ();

   sync_len_checksum_deframer_core #(.MAX_FRAME_BYTES(FRAME_MAX)) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   rx_item_type      rx_pending_q[$];
   frame_result_type deframed_q[$];
   rx_item_type      next_item;
   frame_result_type want;
   int               queued_total = 0;
   int               accepted_total = 0;
   int               mismatches = 0;
   bit               steady = 1'b0;
   logic             req_fire = 1'b0;
   logic [15:0]      timeout_set = TIMEOUT_RESET;

   // predictor state
   logic        m_armed;
   logic        m_in_frame;
   logic [7:0]  m_count;
   logic [7:0]  m_len;
   logic [7:0]  m_addr;
   logic [7:0]  m_hz;
   logic [7:0]  m_cmd;
   logic [15:0] m_sum;
   logic [7:0]  m_sum_lo;
   logic [15:0] m_idle;
   logic [15:0] m_timeout;
   logic [7:0]  m_store [STORE_DEPTH];

   always #5ns clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = OP_BYTE;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = 16'h0000;
   end

   task automatic queue_result(input status_type st, input logic [7:0] pb,
                               input logic [5:0] pi, input logic lst);
      frame_result_type r;
      r.status = st;
      r.addr = m_addr;
      r.hz = m_hz;
      r.cmd = m_cmd;
      r.pbyte = pb;
      r.pidx = pi;
      r.last = lst;
      deframed_q.push_back(r);
   endtask

   task automatic close_frame(input status_type st);
      m_in_frame = 1'b0;
      m_armed = 1'b0;
      queue_result(st, 8'h00, 6'd0, 1'b1);
   endtask

   task automatic deframe_step(input op_type op, input logic [7:0] b);
      int cnt;
      int n;
      bit done;
      done = 1'b0;
      if (op == OP_TICK) begin
         if (m_in_frame) begin
            if (m_idle != TICKS_MAX) m_idle++;
            if (m_idle >= m_timeout) close_frame(ST_TIMEOUT);
         end
      end else if (!m_in_frame) begin
         if (m_armed && b == SYNC_SECOND) begin
            m_in_frame = 1'b1;
            m_armed = 1'b0;
            m_count = 8'd0;
            m_len = 8'd0;
            m_addr = 8'd0;
            m_hz = 8'd0;
            m_cmd = 8'd0;
            m_sum = SUM_INIT;
            m_sum_lo = 8'd0;
            m_idle = 16'd0;
         end else begin
            m_armed = (b == SYNC_FIRST);
         end
      end else begin
         m_idle = 16'd0;
         cnt = int'(m_count) + 1;
         m_count = 8'(cnt);
         if (cnt <= HDR_BYTES) begin
            case (cnt)
               1: m_len = b;
               2: m_addr = b;
               3: m_hz = b;
               default: m_cmd = b;
            endcase
            m_sum = m_sum - b;
            if (cnt == HDR_BYTES && m_len < 2) begin
               close_frame(ST_BAD_LEN);
               done = 1'b1;
            end
         end else if (cnt <= int'(m_len) + 2) begin
            if (cnt - 5 < STORE_DEPTH) m_store[cnt - 5] = b;
            m_sum = m_sum - b;
         end else if (cnt == int'(m_len) + 3) begin
            m_sum_lo = b;
         end else if (cnt == int'(m_len) + 4) begin
            done = 1'b1;
            if ({b, m_sum_lo} != m_sum) begin
               close_frame(ST_BAD_SUM);
            end else begin
               m_in_frame = 1'b0;
               m_armed = 1'b0;
               n = int'(m_len) - 2;
               if (n == 0) begin
                  queue_result(ST_EMPTY, 8'h00, 6'd0, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++)
                     queue_result(ST_PAYLOAD, (i < STORE_DEPTH) ? m_store[i] : 8'h00,
                                  6'(i), i == n - 1);
               end
            end
         end
         if (!done && cnt >= FRAME_MAX) close_frame(ST_OVERFLOW);
      end
   endtask

   // monitor: predicts on every accepted input and checks every accepted result
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         m_armed = 1'b0;
         m_in_frame = 1'b0;
         m_count = 8'd0;
         m_len = 8'd0;
         m_addr = 8'd0;
         m_hz = 8'd0;
         m_cmd = 8'd0;
         m_sum = SUM_INIT;
         m_sum_lo = 8'd0;
         m_idle = 16'd0;
         m_timeout = TIMEOUT_RESET;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (csr_ch.valid && csr_ch.ready) m_timeout = csr_ch.data;
         if (req_ch.valid && req_ch.ready) begin
            deframe_step(op_type'(req_ch.op), req_ch.rx_byte);
            accepted_total++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (deframed_q.size() == 0) begin
               $error("result with none expected: status %0d", rsp_ch.status);
               mismatches++;
            end else begin
               want = deframed_q.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_ch.status);
                  mismatches++;
               end
               if (rsp_ch.frame_addr !== want.addr) begin
                  $error("frame_addr expected %0h actual %0h", want.addr, rsp_ch.frame_addr);
                  mismatches++;
               end
               if (rsp_ch.frame_hz !== want.hz) begin
                  $error("frame_hz expected %0h actual %0h", want.hz, rsp_ch.frame_hz);
                  mismatches++;
               end
               if (rsp_ch.frame_cmd !== want.cmd) begin
                  $error("frame_cmd expected %0h actual %0h", want.cmd, rsp_ch.frame_cmd);
                  mismatches++;
               end
               if (rsp_ch.payload_byte !== want.pbyte) begin
                  $error("payload_byte expected %0h actual %0h", want.pbyte,
                         rsp_ch.payload_byte);
                  mismatches++;
               end
               if (rsp_ch.payload_index !== want.pidx) begin
                  $error("payload_index expected %0d actual %0d", want.pidx,
                         rsp_ch.payload_index);
                  mismatches++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last expected %0b actual %0b", want.last, rsp_ch.last);
                  mismatches++;
               end
            end
         end
      end
   end

   // driver: one transaction per handshake, random gaps unless steady
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
         if (!req_ch.valid || req_fire) begin
            if (rx_pending_q.size() > 0 && (steady || $urandom_range(0, 99) >= 16)) begin
               next_item = rx_pending_q.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.op <= next_item.op;
               req_ch.rx_byte <= next_item.rx_byte;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   task automatic push_item(input op_type op, input logic [7:0] b);
      rx_item_type it;
      it.op = op;
      it.rx_byte = b;
      rx_pending_q.push_back(it);
      queued_total++;
   endtask

   task automatic push_ticks(input int count);
      repeat (count) push_item(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   // sync pair, header, payload and checksum; cut >= 0 stops after that many bytes
   task automatic add_frame(input int len, input bit bad_sum, input int cut,
                            input int tick_max);
      logic [7:0]  body[$];
      logic [15:0] sum;
      int          total;
      sum = SUM_INIT;
      body.push_back(8'(len));
      repeat (3) body.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < len - 2 && body.size() < FRAME_MAX; i++)
         body.push_back(8'($urandom_range(0, 255)));
      foreach (body[i]) sum = sum - body[i];
      if (bad_sum) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
      if (len >= 2) begin
         body.push_back(sum[7:0]);
         body.push_back(sum[15:8]);
      end
      total = (body.size() > FRAME_MAX) ? FRAME_MAX : body.size();
      if (cut >= 0 && cut < total) total = cut;
      push_item(OP_BYTE, SYNC_FIRST);
      push_item(OP_BYTE, SYNC_SECOND);
      for (int i = 0; i < total; i++) begin
         if (tick_max > 0 && $urandom_range(0, 7) == 0) push_ticks($urandom_range(1, tick_max));
         push_item(OP_BYTE, body[i]);
      end
   endtask

   task automatic random_traffic(input int n_items, input int tick_max);
      int stop;
      int r;
      int len;
      stop = queued_total + n_items;
      while (queued_total < stop) begin
         r = $urandom_range(0, 99);
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(2, 12);
         if (r < 65) begin
            add_frame(len, 1'b0, -1, tick_max);
         end else if (r < 77) begin
            add_frame(len, 1'b1, -1, tick_max);
         end else if (r < 85) begin
            // frame broken off, then left to time out (ticks are pushed only for a timeout of at most 300)
            add_frame(len, 1'b0, $urandom_range(0, len + 3), 0);
            if (timeout_set <= 300) push_ticks(int'(timeout_set) + 1);
         end else if (r < 88) begin
            add_frame($urandom_range(0, 1), 1'b0, -1, tick_max);
         end else if (r < 91) begin
            add_frame($urandom_range(61, 255), 1'b0, -1, tick_max);
         end else begin
            repeat ($urandom_range(1, 4))
               push_item(op_type'($urandom_range(0, 1)),
                         ($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic drain_results();
      do @(negedge clock);
      while (accepted_total != queued_total || deframed_q.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= v;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      timeout_set = v;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset timeout
      push_ticks(2);
      push_item(OP_BYTE, 8'h00);
      push_item(OP_BYTE, 8'hFF);
      push_item(OP_BYTE, SYNC_FIRST);
      add_frame(2, 1'b0, -1, 0);
      add_frame(3, 1'b0, -1, 1);
      add_frame(4, 1'b1, -1, 0);
      add_frame(0, 1'b0, -1, 0);
      add_frame(1, 1'b0, -1, 0);
      push_item(OP_BYTE, SYNC_FIRST);
      push_item(OP_BYTE, 8'h00);
      push_item(OP_BYTE, SYNC_SECOND);
      // header cut short, then timed out
      add_frame(6, 1'b0, 2, 0);
      push_ticks(int'(TIMEOUT_RESET));
      add_frame(STORE_DEPTH + 2, 1'b0, -1, 0);
      add_frame(STORE_DEPTH + 3, 1'b0, -1, 0);
      drain_results();

      // zero timeout: first tick inside a frame drops it
      write_timeout(16'd0);
      push_ticks(1);
      add_frame(5, 1'b0, -1, 0);
      add_frame(5, 1'b0, 3, 0);
      push_ticks(1);
      add_frame(2, 1'b0, -1, 0);
      drain_results();

      write_timeout(16'd1);
      random_traffic(20, 2);
      drain_results();

      write_timeout(16'($urandom_range(2, 12)));
      steady = 1'b1;
      random_traffic(50, 4);
      drain_results();
      steady = 1'b0;

      write_timeout(TICKS_MAX);
      random_traffic(10, 8);
      drain_results();

      if (mismatches == 0)
         $display("[sync_len_checksum_deframer_core] OK");
      else
         $display("[sync_len_checksum_deframer_core] ERROR");
      $finish;
   end

   initial begin
      #10ms;
      $display("[sync_len_checksum_deframer_core] ERROR");
      $finish;
   end

endmodule
